@@ hdl/afd_pkg.sv @@
// Package for the ASCII frame deframer: sizes, codes and shared types.
package afd_pkg;

    localparam int MAX_BLOCKS = 3;
    localparam int CMD_CHARS  = 4;
    localparam int MSG_CHARS  = 10;

    localparam int CMD_DEPTH = MAX_BLOCKS * CMD_CHARS;
    localparam int MSG_DEPTH = MAX_BLOCKS * MSG_CHARS;
    localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int BLK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMD_CW    = $clog2(CMD_CHARS + 1);
    localparam int MSG_CW    = $clog2(MSG_CHARS + 1);
    localparam int IDX_W     = (MSG_CW > CMD_CW) ? MSG_CW : CMD_CW;

    localparam int PADDR_W   = 4;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] RST_START  = 8'h26;
    localparam logic [7:0] RST_STOP   = 8'h24;
    localparam logic [7:0] RST_SEP    = 8'h3A;
    localparam logic [7:0] RST_ACK    = 8'h41;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_STOP  = 2'd1,
        REG_SEP   = 2'd2,
        REG_ACK   = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        P_IDLE,
        P_ID,
        P_COUNT,
        P_CMD,
        P_MSG,
        P_ACKID,
        P_CHECK
    } t_parse;

    typedef enum logic [1:0] {
        S_PARSE,
        S_ACK,
        S_CHR,
        S_DONE
    } t_seq;

    typedef enum logic [1:0] {
        K_ACK  = 2'd0,
        K_CMD  = 2'd1,
        K_MSG  = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic              done;
        logic              is_msg;
        logic [BLK_W-1:0]  blk;
        logic [IDX_W-1:0]  idx;
    } t_cur;

endpackage

@@ hdl/afd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module afd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ascii_frame_deframer_with_ack.sv @@
// Top level of the ASCII frame deframer with acknowledge output.
//
// Input channel: one received byte per beat (i_valid / o_stall) with its
// framing and overrun flags; a flagged byte is taken and dropped.
// Output channel: result beats (o_valid / i_stall). A frame closed by the
// stop byte yields four ack bytes, the stored command and message
// characters of each block, then a done record with o_last high.
// Config: APB-style, four 8-bit registers at 0x0, 0x4, 0x8, 0xC (start,
// stop, separator, ack type); write only while the block is idle.
// Timing: a byte that does not close a frame is absorbed without a stall.
// After the stop byte, o_stall stays high while the run is produced from
// the command and message RAMs, one result per cycle when the receiver
// does not stall. o_valid rises once the sequencer has entered the ack
// state and loaded the first ack byte into the output register. A stall
// on the output freezes the sequencer and the held result; input stays
// stalled until the done beat has been loaded into the output register,
// which keeps its own copy of the frame fields.
// Reset: parser idle, counts and lengths zero, registers to their defaults;
// RAM contents are left as they are and only written entries are read.
module ascii_frame_deframer_with_ack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_framing_error,
    input  logic                         i_overrun_error,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_out_kind,
    output logic [7:0]                   o_out_byte,
    output logic [1:0]                   o_block_index,
    output logic [7:0]                   o_frame_id,
    output logic [1:0]                   o_block_count,
    output logic [7:0]                   o_ack_id,
    output logic [7:0]                   o_check_value,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int BW = afd_pkg::BLK_W;
    localparam int IW = afd_pkg::IDX_W;
    localparam int CW = afd_pkg::CMD_CW;
    localparam int MW = afd_pkg::MSG_CW;
    localparam int NB = afd_pkg::MAX_BLOCKS;

    // config registers
    logic [7:0] r_start_char, r_stop_char, r_sep_char, r_ack_char;

    // parser state
    afd_pkg::t_parse        r_parse, n_parse;
    afd_pkg::t_seq          r_seq, n_seq;
    logic [7:0]             r_id, n_id;
    logic [BW-1:0]          r_bexp, n_bexp;
    logic [BW-1:0]          r_bleft, n_bleft;
    logic [BW-1:0]          r_bfill, n_bfill;
    logic [NB-1:0][CW-1:0]  r_cmd_len, n_cmd_len;
    logic [NB-1:0][MW-1:0]  r_msg_len, n_msg_len;
    logic [CW-1:0]          r_cmd_cnt, n_cmd_cnt;
    logic [MW-1:0]          r_msg_cnt, n_msg_cnt;
    logic [7:0]             r_ackid, n_ackid;
    logic [7:0]             r_check, n_check;

    // emit sequencer
    logic [1:0]             r_ack_idx, n_ack_idx;
    afd_pkg::t_cur          r_cur, n_cur;
    afd_pkg::t_cur          seed, norm;

    // output register
    logic                   r_ov, n_ov;
    logic [1:0]             r_kind, n_kind;
    logic [7:0]             r_byte, n_byte;
    logic [BW-1:0]          r_bidx, n_bidx;
    logic                   r_done, n_done;
    logic [7:0]             r_fid, n_fid;
    logic [BW-1:0]          r_bcnt, n_bcnt;
    logic [7:0]             r_aid, n_aid;
    logic [7:0]             r_chk, n_chk;

    // RAM ports
    logic                        cmd_we, msg_we, rd_en;
    logic [afd_pkg::CMD_AW-1:0]  cmd_waddr, cmd_raddr;
    logic [afd_pkg::MSG_AW-1:0]  msg_waddr, msg_raddr;
    logic [7:0]                  cmd_rdata, msg_rdata;
    logic [CW-1:0]               cmd_widx;
    logic [MW-1:0]               msg_widx;

    logic in_acc, good, is_stop, is_sep, out_free, cfg_wr, fill_ok;

    function automatic afd_pkg::t_cur f_norm(
        afd_pkg::t_cur         s,
        logic [BW-1:0]         bexp,
        logic [NB-1:0][CW-1:0] cl,
        logic [NB-1:0][MW-1:0] ml
    );
        afd_pkg::t_cur c;
        logic          fin;
        c   = s;
        fin = 1'b0;
        for (int k = 0; k < 2 * NB + 1; k++) begin
            if (!fin) begin
                if (c.blk >= bexp || c.blk >= BW'(NB)) begin
                    c.done = 1'b1;
                    fin    = 1'b1;
                end else if (!c.is_msg) begin
                    if (c.idx < IW'(cl[c.blk])) begin
                        fin = 1'b1;
                    end else begin
                        c.is_msg = 1'b1;
                        c.idx    = '0;
                    end
                end else begin
                    if (c.idx < IW'(ml[c.blk])) begin
                        fin = 1'b1;
                    end else begin
                        c.is_msg = 1'b0;
                        c.idx    = '0;
                        c.blk    = c.blk + BW'(1);
                    end
                end
            end
        end
        return c;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_stall  = (r_seq != afd_pkg::S_PARSE);
    assign in_acc   = i_valid && !o_stall;
    assign good     = in_acc && !i_framing_error && !i_overrun_error;
    assign is_stop  = (i_rx_byte == r_stop_char);
    assign is_sep   = (i_rx_byte == r_sep_char);
    assign out_free = !r_ov || !i_stall;
    assign fill_ok  = (r_bfill < BW'(NB));

    always_comb begin
        case (afd_pkg::t_reg'(paddr[3:2]))
            afd_pkg::REG_START: prdata = {24'd0, r_start_char};
            afd_pkg::REG_STOP:  prdata = {24'd0, r_stop_char};
            afd_pkg::REG_SEP:   prdata = {24'd0, r_sep_char};
            afd_pkg::REG_ACK:   prdata = {24'd0, r_ack_char};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= afd_pkg::RST_START;
            r_stop_char  <= afd_pkg::RST_STOP;
            r_sep_char   <= afd_pkg::RST_SEP;
            r_ack_char   <= afd_pkg::RST_ACK;
        end else if (cfg_wr) begin
            case (afd_pkg::t_reg'(paddr[3:2]))
                afd_pkg::REG_START: r_start_char <= pwdata[7:0];
                afd_pkg::REG_STOP:  r_stop_char  <= pwdata[7:0];
                afd_pkg::REG_SEP:   r_sep_char   <= pwdata[7:0];
                afd_pkg::REG_ACK:   r_ack_char   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // cursor seed: first element after the ack bytes, or the one after r_cur
    always_comb begin
        seed = r_cur;
        seed.done = 1'b0;
        if (r_seq == afd_pkg::S_ACK) begin
            seed = '0;
        end else begin
            seed.idx = r_cur.idx + IW'(1);
        end
        norm = f_norm(seed, r_bexp, r_cmd_len, r_msg_len);
    end

    // next state
    always_comb begin
        n_seq   = r_seq;
        n_parse = r_parse;
        case (r_seq)
            afd_pkg::S_PARSE: begin
                if (good) begin
                    case (r_parse)
                        afd_pkg::P_IDLE: begin
                            if (i_rx_byte == r_start_char) n_parse = afd_pkg::P_ID;
                        end
                        afd_pkg::P_ID: begin
                            if (is_sep) n_parse = afd_pkg::P_COUNT;
                        end
                        afd_pkg::P_COUNT: begin
                            if (is_sep) n_parse = afd_pkg::P_CMD;
                        end
                        afd_pkg::P_CMD: begin
                            if (is_sep) n_parse = afd_pkg::P_MSG;
                        end
                        afd_pkg::P_MSG: begin
                            if (is_sep) begin
                                n_parse = (r_bleft <= BW'(1)) ? afd_pkg::P_ACKID
                                                              : afd_pkg::P_CMD;
                            end
                        end
                        afd_pkg::P_ACKID: begin
                            if (is_sep) n_parse = afd_pkg::P_CHECK;
                        end
                        afd_pkg::P_CHECK: begin
                            if (is_stop) begin
                                n_parse = afd_pkg::P_IDLE;
                                n_seq   = afd_pkg::S_ACK;
                            end
                        end
                        default: n_parse = afd_pkg::P_IDLE;
                    endcase
                end
            end
            afd_pkg::S_ACK: begin
                if (out_free && r_ack_idx == 2'd3) begin
                    n_seq = norm.done ? afd_pkg::S_DONE : afd_pkg::S_CHR;
                end
            end
            afd_pkg::S_CHR: begin
                if (out_free) begin
                    n_seq = norm.done ? afd_pkg::S_DONE : afd_pkg::S_CHR;
                end
            end
            afd_pkg::S_DONE: begin
                if (out_free) n_seq = afd_pkg::S_PARSE;
            end
            default: n_seq = afd_pkg::S_PARSE;
        endcase
    end

    assign cmd_widx  = (r_cmd_cnt >= CW'(afd_pkg::CMD_CHARS)) ? '0 : r_cmd_cnt;
    assign msg_widx  = (r_msg_cnt >= MW'(afd_pkg::MSG_CHARS)) ? '0 : r_msg_cnt;
    assign cmd_waddr = afd_pkg::CMD_AW'(r_bfill) * afd_pkg::CMD_AW'(afd_pkg::CMD_CHARS)
                     + afd_pkg::CMD_AW'(cmd_widx);
    assign msg_waddr = afd_pkg::MSG_AW'(r_bfill) * afd_pkg::MSG_AW'(afd_pkg::MSG_CHARS)
                     + afd_pkg::MSG_AW'(msg_widx);
    assign cmd_raddr = afd_pkg::CMD_AW'(norm.blk) * afd_pkg::CMD_AW'(afd_pkg::CMD_CHARS)
                     + afd_pkg::CMD_AW'(norm.idx);
    assign msg_raddr = afd_pkg::MSG_AW'(norm.blk) * afd_pkg::MSG_AW'(afd_pkg::MSG_CHARS)
                     + afd_pkg::MSG_AW'(norm.idx);

    assign cmd_we = (r_seq == afd_pkg::S_PARSE) && good && (r_parse == afd_pkg::P_CMD)
                    && !is_sep && fill_ok;
    assign msg_we = (r_seq == afd_pkg::S_PARSE) && good && (r_parse == afd_pkg::P_MSG)
                    && !is_sep && fill_ok;
    assign rd_en  = out_free && !norm.done
                    && ((r_seq == afd_pkg::S_ACK && r_ack_idx == 2'd3)
                        || r_seq == afd_pkg::S_CHR);

    // datapath and outputs
    always_comb begin
        n_id      = r_id;
        n_bexp    = r_bexp;
        n_bleft   = r_bleft;
        n_bfill   = r_bfill;
        n_cmd_len = r_cmd_len;
        n_msg_len = r_msg_len;
        n_cmd_cnt = r_cmd_cnt;
        n_msg_cnt = r_msg_cnt;
        n_ackid   = r_ackid;
        n_check   = r_check;
        n_ack_idx = r_ack_idx;
        n_cur     = r_cur;
        n_ov      = r_ov && i_stall;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_bidx    = r_bidx;
        n_done    = r_done;
        n_fid     = r_fid;
        n_bcnt    = r_bcnt;
        n_aid     = r_aid;
        n_chk     = r_chk;
        case (r_seq)
            afd_pkg::S_PARSE: begin
                if (good) begin
                    case (r_parse)
                        afd_pkg::P_IDLE: begin
                            if (i_rx_byte == r_start_char) begin
                                n_id      = '0;
                                n_bexp    = '0;
                                n_bleft   = '0;
                                n_bfill   = '0;
                                n_cmd_cnt = '0;
                                n_msg_cnt = '0;
                            end
                        end
                        afd_pkg::P_ID: begin
                            if (!is_sep) n_id = i_rx_byte;
                        end
                        afd_pkg::P_COUNT: begin
                            if (is_sep) begin
                                if (r_bexp == '0) begin
                                    n_bexp  = BW'(1);
                                    n_bleft = BW'(1);
                                end
                            end else if (i_rx_byte <= afd_pkg::DIGIT_ZERO) begin
                                n_bexp  = BW'(1);
                                n_bleft = BW'(1);
                            end else if (i_rx_byte >= afd_pkg::DIGIT_ZERO + 8'(NB)) begin
                                n_bexp  = BW'(NB);
                                n_bleft = BW'(NB);
                            end else begin
                                n_bexp  = BW'(i_rx_byte - afd_pkg::DIGIT_ZERO);
                                n_bleft = BW'(i_rx_byte - afd_pkg::DIGIT_ZERO);
                            end
                        end
                        afd_pkg::P_CMD: begin
                            if (!is_sep && fill_ok) n_cmd_cnt = cmd_widx + CW'(1);
                        end
                        afd_pkg::P_MSG: begin
                            if (is_sep) begin
                                if (fill_ok) begin
                                    n_cmd_len[r_bfill[BW-1:0]] = r_cmd_cnt;
                                    n_msg_len[r_bfill[BW-1:0]] = r_msg_cnt;
                                end
                                n_cmd_cnt = '0;
                                n_msg_cnt = '0;
                                n_bfill   = r_bfill + BW'(1);
                                if (r_bleft != '0) n_bleft = r_bleft - BW'(1);
                            end else if (fill_ok) begin
                                n_msg_cnt = msg_widx + MW'(1);
                            end
                        end
                        afd_pkg::P_ACKID: begin
                            if (!is_sep) n_ackid = i_rx_byte;
                        end
                        afd_pkg::P_CHECK: begin
                            if (!is_stop) n_check = i_rx_byte;
                            else          n_ack_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            afd_pkg::S_ACK: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_kind = afd_pkg::K_ACK;
                    n_bidx = '0;
                    n_done = 1'b0;
                    n_fid  = '0;
                    n_bcnt = '0;
                    n_aid  = '0;
                    n_chk  = '0;
                    case (r_ack_idx)
                        2'd0:    n_byte = r_start_char;
                        2'd1:    n_byte = r_ack_char;
                        2'd2:    n_byte = r_ackid;
                        default: n_byte = r_stop_char;
                    endcase
                    n_ack_idx = r_ack_idx + 2'd1;
                    if (r_ack_idx == 2'd3) n_cur = norm;
                end
            end
            afd_pkg::S_CHR: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_kind = r_cur.is_msg ? afd_pkg::K_MSG : afd_pkg::K_CMD;
                    n_byte = r_cur.is_msg ? msg_rdata : cmd_rdata;
                    n_bidx = r_cur.blk;
                    n_done = 1'b0;
                    n_fid  = '0;
                    n_bcnt = '0;
                    n_aid  = '0;
                    n_chk  = '0;
                    n_cur  = norm;
                end
            end
            afd_pkg::S_DONE: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_kind = afd_pkg::K_DONE;
                    n_byte = '0;
                    n_bidx = '0;
                    n_done = 1'b1;
                    n_fid  = r_id;
                    n_bcnt = r_bexp;
                    n_aid  = r_ackid;
                    n_chk  = r_check;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= afd_pkg::S_PARSE;
            r_parse   <= afd_pkg::P_IDLE;
            r_id      <= '0;
            r_bexp    <= '0;
            r_bleft   <= '0;
            r_bfill   <= '0;
            r_cmd_len <= '0;
            r_msg_len <= '0;
            r_cmd_cnt <= '0;
            r_msg_cnt <= '0;
            r_ackid   <= '0;
            r_check   <= '0;
            r_ack_idx <= '0;
            r_cur     <= '0;
            r_ov      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_parse   <= n_parse;
            r_id      <= n_id;
            r_bexp    <= n_bexp;
            r_bleft   <= n_bleft;
            r_bfill   <= n_bfill;
            r_cmd_len <= n_cmd_len;
            r_msg_len <= n_msg_len;
            r_cmd_cnt <= n_cmd_cnt;
            r_msg_cnt <= n_msg_cnt;
            r_ackid   <= n_ackid;
            r_check   <= n_check;
            r_ack_idx <= n_ack_idx;
            r_cur     <= n_cur;
            r_ov      <= n_ov;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_bidx <= n_bidx;
        r_fid  <= n_fid;
        r_bcnt <= n_bcnt;
        r_aid  <= n_aid;
        r_chk  <= n_chk;
    end

    // writes happen only while parsing, reads only while emitting
    afd_ram #(
        .WIDTH (8),
        .DEPTH (afd_pkg::CMD_DEPTH)
    ) u_cmd_ram (
        .i_clk   (i_clk),
        .i_we    (cmd_we),
        .i_waddr (cmd_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (cmd_raddr),
        .o_rdata (cmd_rdata)
    );

    afd_ram #(
        .WIDTH (8),
        .DEPTH (afd_pkg::MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (msg_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rdata)
    );

    assign o_valid       = r_ov;
    assign o_out_kind    = r_kind;
    assign o_out_byte    = r_byte;
    assign o_block_index = r_bidx;
    assign o_frame_id    = r_fid;
    assign o_block_count = r_bcnt;
    assign o_ack_id      = r_aid;
    assign o_check_value = r_chk;
    assign o_last        = r_done;

`ifndef NO_ASSERTIONS
    a_stop_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good && r_parse == afd_pkg::P_CHECK && is_stop |=> r_seq == afd_pkg::S_ACK)
        else $error("stop byte did not start the ack run");

    a_done_loads_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq == afd_pkg::S_DONE && out_free |=> o_valid && o_last)
        else $error("done record not presented");

    a_emit_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq != afd_pkg::S_PARSE |-> r_parse == afd_pkg::P_IDLE)
        else $error("emitting while a frame is open");

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_out_kind == afd_pkg::K_DONE)
        else $error("last flag on a non-done beat");

    a_left_le_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bleft <= r_bexp)
        else $error("blocks left exceeds blocks expected");
`endif

endmodule
